// ----- rtl/core/glvm_pkg.sv -----
// ----------------------------------------------------------------------------
// glvm_pkg
// Item types and fixed widths for the equivalent strain pipeline.
// ----------------------------------------------------------------------------
package glvm_pkg;

    localparam int TAG_W  = 16;
    localparam int FW     = 20;
    localparam int ROOT_W = 32;

    // product of two entries, entry of f^t f, magnitude of a difference
    localparam int PW   = 2 * FW;
    localparam int CW   = PW + 1;
    localparam int MW   = PW;
    localparam int HW   = MW / 2;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;
    localparam int QW   = SQW + 4;

    localparam int N_C   = 6;
    localparam int N_FE  = 7;

    // row and column of each distinct entry of f^t f: xx yy zz xy yz xz
    localparam int C_ROW [N_C] = '{0, 1, 2, 0, 1, 0};
    localparam int C_COL [N_C] = '{0, 1, 2, 1, 2, 2};
    // partner of each normal entry in the difference terms
    localparam int D_NXT [3] = '{1, 2, 0};

    typedef struct packed {
        logic [TAG_W-1:0]     particle_index;
        logic signed [FW-1:0] f_xx;
        logic signed [FW-1:0] f_xy;
        logic signed [FW-1:0] f_xz;
        logic signed [FW-1:0] f_yx;
        logic signed [FW-1:0] f_yy;
        logic signed [FW-1:0] f_yz;
        logic signed [FW-1:0] f_zx;
        logic signed [FW-1:0] f_zy;
        logic signed [FW-1:0] f_zz;
    } glvm_in_t;

    typedef struct packed {
        logic [TAG_W-1:0]  particle_tag;
        logic [ROOT_W-1:0] equivalent_strain;
    } glvm_out_t;

endpackage

// ----- rtl/core/green_lagrange_von_mises_strain_unit.sv -----
// ----------------------------------------------------------------------------
// green_lagrange_von_mises_strain_unit
// Von Mises equivalent strain of a 3x3 deformation gradient through the
// Green-Lagrange strain, unsigned fixed point, saturating, tag passed along.
// ----------------------------------------------------------------------------
//  channel   signals                 transfer
//  item      start, busy, item       start high and busy low at clk rise
//  result    done, result            done high for one cycle, always taken
//
//  one item per cycle
//  7 arithmetic stages (products, f^t f, differences, square partial
//  products, squares, sums, weighted sum) plus 32 root stages, one bit each
//  busy stays low: the receiver cannot stall, so the pipeline never waits
//  reset clears the valid bits; items in flight are dropped
// ----------------------------------------------------------------------------
module green_lagrange_von_mises_strain_unit
    import glvm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  glvm_in_t  item,
    output logic      busy,
    output logic      done,
    output glvm_out_t result
);

    localparam int LAT = N_FE + ROOT_W;

    logic signed [FW-1:0] fm [3][3];

    logic [N_FE-1:0]       v_reg;
    logic [TAG_W-1:0]      tag_reg [N_FE];
    logic signed [PW-1:0]  prod_reg [N_C][3];
    logic signed [CW-1:0]  c_reg [N_C];
    logic signed [CW:0]    dv [N_C];
    logic [CW:0]           av [N_C];
    logic [MW-1:0]         mag_next [N_C];
    logic [MW-1:0]         mag_reg [N_C];
    logic [PW-1:0]         pp_reg [N_C][3];
    logic [SQW-1:0]        sq_reg [N_C];
    logic [SUMW-1:0]       sa_reg;
    logic [SUMW-1:0]       sb_reg;
    logic [QW-1:0]         q_reg;

    logic                  root_valid;
    logic [TAG_W-1:0]      root_tag;
    logic [ROOT_W-1:0]     root;

    assign busy = 1'b0;

    always_comb
    begin
        fm[0][0] = item.f_xx;
        fm[0][1] = item.f_xy;
        fm[0][2] = item.f_xz;
        fm[1][0] = item.f_yx;
        fm[1][1] = item.f_yy;
        fm[1][2] = item.f_yz;
        fm[2][0] = item.f_zx;
        fm[2][1] = item.f_zy;
        fm[2][2] = item.f_zz;
    end

    // normal differences and shear entries, then magnitudes
    always_comb
    begin
        for (int e = 0; e < N_C; e++)
        begin
            if (e < 3)
            begin
                dv[e] = (CW + 1)'(c_reg[e]) - (CW + 1)'(c_reg[D_NXT[e]]);
            end
            else
            begin
                dv[e] = (CW + 1)'(c_reg[e]);
            end
            av[e]       = dv[e][CW] ? (~dv[e] + 1'b1) : dv[e];
            mag_next[e] = av[e][MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N_FE-2:0], start && !busy};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= item.particle_index;
        for (int s = 1; s < N_FE; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end

        for (int e = 0; e < N_C; e++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[e][a] <= fm[a][C_ROW[e]] * fm[a][C_COL[e]];
            end
            c_reg[e]     <= CW'(prod_reg[e][0]) + CW'(prod_reg[e][1])
                          + CW'(prod_reg[e][2]);
            mag_reg[e]   <= mag_next[e];
            pp_reg[e][0] <= PW'(mag_reg[e][MW-1:HW]) * PW'(mag_reg[e][MW-1:HW]);
            pp_reg[e][1] <= PW'(mag_reg[e][MW-1:HW]) * PW'(mag_reg[e][HW-1:0]);
            pp_reg[e][2] <= PW'(mag_reg[e][HW-1:0]) * PW'(mag_reg[e][HW-1:0]);
            sq_reg[e]    <= (SQW'(pp_reg[e][0]) << (2 * HW))
                          + (SQW'(pp_reg[e][1]) << (HW + 1))
                          + SQW'(pp_reg[e][2]);
        end

        sa_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        sb_reg <= SUMW'(sq_reg[3]) + SUMW'(sq_reg[4]) + SUMW'(sq_reg[5]);
        // shear squares weigh six times
        q_reg  <= QW'(sa_reg) + (QW'(sb_reg) << 2) + (QW'(sb_reg) << 1);
    end

    glvm_isqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .qv         (v_reg[N_FE-1]),
        .q_tag      (tag_reg[N_FE-1]),
        .q          (q_reg),
        .root_valid (root_valid),
        .root_tag   (root_tag),
        .root       (root)
    );

    assign done                     = root_valid;
    assign result.particle_tag      = root_tag;
    assign result.equivalent_strain = root;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching item");

    a_tag_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.particle_tag == $past(item.particle_index, LAT)))
        else $error("tag out of step with result");

endmodule

// ----- rtl/core/glvm_isqrt.sv -----
// ----------------------------------------------------------------------------
// glvm_isqrt
// Pipelined square root, one root bit per stage: largest y with
// 3 * y^2 * 2^(2*FRAC_BITS+2) <= q, limited to the root width.
// ----------------------------------------------------------------------------
module glvm_isqrt
    import glvm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              qv,
    input  logic [TAG_W-1:0]  q_tag,
    input  logic [QW-1:0]     q,
    output logic              root_valid,
    output logic [TAG_W-1:0]  root_tag,
    output logic [ROOT_W-1:0] root
);

    localparam int K   = 2 * FRAC_BITS + 2;
    localparam int RW  = K + ROOT_W + 36;
    localparam int Y3W = ROOT_W + 2;
    localparam int N   = ROOT_W;

    logic [N-1:0]      valid_reg;
    logic [TAG_W-1:0]  tag_reg [N];
    logic [RW-1:0]     rem_reg [N];
    logic [ROOT_W-1:0] y_reg   [N];
    logic [Y3W-1:0]    y3_reg  [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam int B = N - 1 - i;

        logic              src_valid;
        logic [TAG_W-1:0]  src_tag;
        logic [RW-1:0]     src_rem;
        logic [ROOT_W-1:0] src_y;
        logic [Y3W-1:0]    src_y3;
        logic [RW-1:0]     term;
        logic [RW:0]       diff;
        logic              fit;
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] y_next;
        logic [Y3W-1:0]    y3_next;

        if (i == 0) begin : g_first
            assign src_valid = qv;
            assign src_tag   = q_tag;
            assign src_rem   = RW'(q);
            assign src_y     = '0;
            assign src_y3    = '0;
        end
        else begin : g_next
            assign src_valid = valid_reg[i-1];
            assign src_tag   = tag_reg[i-1];
            assign src_rem   = rem_reg[i-1];
            assign src_y     = y_reg[i-1];
            assign src_y3    = y3_reg[i-1];
        end

        // 3*((y + 2^b)^2 - y^2) scaled, with 3y kept alongside y
        assign term = ((RW'(src_y3) << (B + 1)) | (RW'(2'd3) << (2 * B))) << K;
        assign diff = {1'b0, src_rem} - {1'b0, term};
        assign fit  = !diff[RW];

        assign rem_next = fit ? diff[RW-1:0] : src_rem;
        assign y_next   = fit ? (src_y | (ROOT_W'(1) << B)) : src_y;
        assign y3_next  = fit ? (src_y3 + (Y3W'(3) << B)) : src_y3;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[i] <= src_tag;
            rem_reg[i] <= rem_next;
            y_reg[i]   <= y_next;
            y3_reg[i]  <= y3_next;
        end
    end

    assign root_valid = valid_reg[N-1];
    assign root_tag   = tag_reg[N-1];
    assign root       = y_reg[N-1];

    a_y3_tracks_y: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N-1] |->
            (y3_reg[N-1] == ({2'b00, y_reg[N-1]} + {1'b0, y_reg[N-1], 1'b0})))
        else $error("running 3y does not match root");

    a_root_latency: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N-1] |-> $past(qv, N))
        else $error("root valid without radicand");

endmodule
